### src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/gctf_pkg.sv
// shared types, constants and helper functions of the grid clearance target finder
package gctf_pkg;

   // distance words, unsigned fixed point, all ones is infinity
   localparam int DIST_W = 16;
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   // register field widths
   localparam int GRID_DIM_W = 7;
   localparam int SAFE_W     = 16;
   localparam int ARRIVAL_W  = 13;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // result field widths
   localparam int OUTCOME_W = 2;
   localparam int OFFSET_W  = 7;

   // reset values of the registers
   localparam logic [GRID_DIM_W-1:0] GRID_WIDTH_RST  = 7'd64;
   localparam logic [GRID_DIM_W-1:0] GRID_HEIGHT_RST = 7'd64;
   localparam logic [SAFE_W-1:0]     SAFE_RST        = 16'd512;
   localparam logic [ARRIVAL_W-1:0]  ARRIVAL_RST     = 13'd4;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_SAFE        = 2'd2,
      REG_ARRIVAL     = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD,
      ST_BWD,
      ST_FIN,
      ST_REPORT
   } state_type;

   // per cell steps: read cell, read four neighbours, write back
   typedef enum logic [2:0] {
      PH_CELL,
      PH_NB0,
      PH_NB1,
      PH_NB2,
      PH_NB3,
      PH_WRITE
   } phase_type;

   typedef enum logic [1:0] {
      RLX_HOLD,
      RLX_LOAD_MAP,
      RLX_LOAD_RAW,
      RLX_MIN
   } relax_op_type;

   typedef enum logic [1:0] {
      OUT_SAFE    = 2'd0,
      OUT_NONE    = 2'd1,
      OUT_ARRIVED = 2'd2,
      OUT_MOVE    = 2'd3
   } outcome_type;

   typedef struct packed {
      relax_op_type op;
      logic         diag;
   } relax_ctrl_type;

   typedef struct packed {
      logic [GRID_DIM_W-1:0] grid_width;
      logic [GRID_DIM_W-1:0] grid_height;
      logic [SAFE_W-1:0]     safe_clearance;
      logic [ARRIVAL_W-1:0]  arrival_sq;
   } cfg_type;

   // sqrt(2) scaled by 2^frac_bits, rounded to nearest, elaboration only
   function automatic int unsigned sqrt2_scaled(input int unsigned frac_bits);
      longint unsigned x;
      longint unsigned r;
      longint unsigned trial;
      x = 64'd2 << (2 * frac_bits);
      r = 64'd0;
      for (int b = 15; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x) begin
            r = trial;
         end
      end
      if (x - r * r > r) begin
         r = r + 64'd1;
      end
      return 32'(r);
   endfunction

endpackage

### src/grid_clearance_target_finder.sv
// Loading: one cell per cycle, busy stays low until the cell flagged last_cell.
// After last_cell is taken, busy stays high until the result is ready; the result strobe
// is high in the first cycle in which busy is low again (items without last_cell give no result).
// Each chamfer pass handles a cell in steps on the single read port of the store
// (cell, four neighbours, write back); the target search rides on the backward pass.
// Reset is synchronous; the distance store is not cleared by it.
`include "assert_macros.svh"

module grid_clearance_target_finder #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [7:0]                      req_cell_cost,
   input  logic                                   req_last_cell,
   output logic                                   rsp_valid,
   output logic [gctf_pkg::OUTCOME_W-1:0]         rsp_outcome,
   output logic [gctf_pkg::DIST_W-1:0]            rsp_centre_clearance,
   output logic signed [gctf_pkg::OFFSET_W-1:0]   rsp_target_dx,
   output logic signed [gctf_pkg::OFFSET_W-1:0]   rsp_target_dy,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [gctf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [gctf_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [gctf_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import gctf_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WV_W   = $clog2(MAX_WIDTH + 1);
   localparam int HV_W   = $clog2(MAX_HEIGHT + 1);
   localparam int N_W    = WV_W + HV_W;
   localparam int DX_W   = WV_W + 1;
   localparam int DY_W   = HV_W + 1;
   localparam int SQX_W  = 2 * DX_W;
   localparam int SQY_W  = 2 * DY_W;
   localparam int D2_W   = ((SQX_W > SQY_W) ? SQX_W : SQY_W) + 1;
   localparam int CMP_W  = (D2_W > ARRIVAL_W) ? D2_W : ARRIVAL_W;
   localparam int NB_COUNT_C = 4;

   // configuration
   cfg_type          cfg;
   logic [8:0]       w_raw;
   logic [8:0]       h_raw;
   logic [WV_W-1:0]  w_eff;
   logic [HV_W-1:0]  h_eff;
   logic [N_W-1:0]   n_cells;
   logic [WV_W-1:0]  ci;
   logic [HV_W-1:0]  cj;

   // load side
   logic             accept;
   logic             load_we;
   logic [N_W-1:0]   load_pos_ff;
   logic [N_W-1:0]   load_pos_in;

   // sequencer
   state_type        state_ff,  state_in;
   phase_type        phase_ff,  phase_in;
   logic [ADDR_W-1:0] k_ff,     k_in;
   logic [WV_W-1:0]  i_ff,      i_in;
   logic [HV_W-1:0]  j_ff,      j_in;
   logic             i_first, i_last, j_first, j_last;
   logic [ADDR_W-1:0] w_a;
   logic [ADDR_W-1:0] nb_addr  [NB_COUNT_C];
   logic             nb_valid [NB_COUNT_C];
   logic             nb_diag  [NB_COUNT_C];
   logic             in_pass;
   logic             calc_we;
   relax_ctrl_type   rctrl;
   logic [ADDR_W-1:0] rd_addr;

   // store and relax unit
   logic             st_we;
   logic [ADDR_W-1:0] st_waddr;
   logic [DIST_W-1:0] st_wdata;
   logic [DIST_W-1:0] st_rdata;
   logic [DIST_W-1:0] cur;
   logic [DIST_W-1:0] nxt;

   // search
   logic signed [DX_W-1:0]  dx_now;
   logic signed [DY_W-1:0]  dy_now;
   logic signed [DX_W-1:0]  dx_ff;
   logic signed [DY_W-1:0]  dy_ff;
   logic signed [SQX_W-1:0] sq_x;
   logic signed [SQY_W-1:0] sq_y;
   logic [D2_W-1:0]         d2_ff;
   logic                    ctr_hit_ff;
   logic                    cell_done_ff;
   logic                    found_ff;
   logic [D2_W-1:0]         best_d2_ff;
   logic signed [DX_W-1:0]  best_dx_ff;
   logic signed [DY_W-1:0]  best_dy_ff;
   logic [DIST_W-1:0]       centre_ff;
   logic                    take_cell;

   // result
   logic                    rsp_valid_ff;
   outcome_type             rsp_outcome_ff;
   outcome_type             outcome_now;
   logic [DIST_W-1:0]       rsp_centre_ff;
   logic signed [OFFSET_W-1:0] rsp_dx_ff;
   logic signed [OFFSET_W-1:0] rsp_dy_ff;
   logic                    rsp_offset_ok;

   gctf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // effective grid size, centre cell and cell count
   always_comb begin
      w_raw = {2'b0, cfg.grid_width};
      h_raw = {2'b0, cfg.grid_height};
      if (w_raw == 9'd0) begin
         w_eff = WV_W'(1);
      end else if (w_raw > 9'(MAX_WIDTH)) begin
         w_eff = WV_W'(MAX_WIDTH);
      end else begin
         w_eff = WV_W'(w_raw);
      end
      if (h_raw == 9'd0) begin
         h_eff = HV_W'(1);
      end else if (h_raw > 9'(MAX_HEIGHT)) begin
         h_eff = HV_W'(MAX_HEIGHT);
      end else begin
         h_eff = HV_W'(h_raw);
      end
      n_cells = N_W'(w_eff) * N_W'(h_eff);
      ci      = w_eff >> 1;
      cj      = h_eff >> 1;
   end

   // load beats
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start & ~busy;
   assign load_we = accept && (load_pos_ff < n_cells);

   always_comb begin
      load_pos_in = load_pos_ff;
      if (accept) begin
         if (req_last_cell) begin
            load_pos_in = '0;
         end else if (load_we) begin
            load_pos_in = load_pos_ff + N_W'(1);
         end
      end
   end

   // neighbour addresses and edge masks for the current cell
   always_comb begin
      w_a     = ADDR_W'(w_eff);
      i_first = (i_ff == '0);
      j_first = (j_ff == '0);
      i_last  = ((i_ff + WV_W'(1)) == w_eff);
      j_last  = ((j_ff + HV_W'(1)) == h_eff);
      if (state_ff == ST_BWD) begin
         nb_addr[0]  = k_ff + ADDR_W'(1);
         nb_valid[0] = !i_last;
         nb_diag[0]  = 1'b0;
         nb_addr[1]  = k_ff + w_a;
         nb_valid[1] = !j_last;
         nb_diag[1]  = 1'b0;
         nb_addr[2]  = k_ff + w_a + ADDR_W'(1);
         nb_valid[2] = !j_last && !i_last;
         nb_diag[2]  = 1'b1;
         nb_addr[3]  = k_ff + w_a - ADDR_W'(1);
         nb_valid[3] = !j_last && !i_first;
         nb_diag[3]  = 1'b1;
      end else begin
         nb_addr[0]  = k_ff - ADDR_W'(1);
         nb_valid[0] = !i_first;
         nb_diag[0]  = 1'b0;
         nb_addr[1]  = k_ff - w_a;
         nb_valid[1] = !j_first;
         nb_diag[1]  = 1'b0;
         nb_addr[2]  = k_ff - w_a - ADDR_W'(1);
         nb_valid[2] = !j_first && !i_first;
         nb_diag[2]  = 1'b1;
         nb_addr[3]  = k_ff - w_a + ADDR_W'(1);
         nb_valid[3] = !j_first && !i_last;
         nb_diag[3]  = 1'b1;
      end
   end

   // read address and relax command per step
   assign in_pass = (state_ff == ST_FWD) || (state_ff == ST_BWD);
   assign calc_we = in_pass && (phase_ff == PH_WRITE);

   always_comb begin
      rd_addr    = k_ff;
      rctrl.op   = RLX_HOLD;
      rctrl.diag = 1'b0;
      if (in_pass) begin
         unique case (phase_ff)
            PH_CELL: begin
               rd_addr = k_ff;
            end
            PH_NB0: begin
               rd_addr  = nb_valid[0] ? nb_addr[0] : k_ff;
               rctrl.op = (state_ff == ST_FWD) ? RLX_LOAD_MAP : RLX_LOAD_RAW;
            end
            PH_NB1: begin
               rd_addr    = nb_valid[1] ? nb_addr[1] : k_ff;
               rctrl.op   = nb_valid[0] ? RLX_MIN : RLX_HOLD;
               rctrl.diag = nb_diag[0];
            end
            PH_NB2: begin
               rd_addr    = nb_valid[2] ? nb_addr[2] : k_ff;
               rctrl.op   = nb_valid[1] ? RLX_MIN : RLX_HOLD;
               rctrl.diag = nb_diag[1];
            end
            PH_NB3: begin
               rd_addr    = nb_valid[3] ? nb_addr[3] : k_ff;
               rctrl.op   = nb_valid[2] ? RLX_MIN : RLX_HOLD;
               rctrl.diag = nb_diag[2];
            end
            PH_WRITE: begin
               rctrl.op   = nb_valid[3] ? RLX_MIN : RLX_HOLD;
               rctrl.diag = nb_diag[3];
            end
            default: begin
               rctrl.op = RLX_HOLD;
            end
         endcase
      end
   end

   // store write port shared by loading and both passes
   assign st_we    = load_we | calc_we;
   assign st_waddr = calc_we ? k_ff : ADDR_W'(load_pos_ff);
   assign st_wdata = calc_we ? nxt : ((req_cell_cost != '0) ? '0 : DIST_INF);

   gctf_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (rd_addr),
      .rdata (st_rdata)
   );

   gctf_relax #(
      .FRAC_BITS (FRAC_BITS)
   ) u_relax (
      .clock (clock),
      .reset (reset),
      .ctrl  (rctrl),
      .word  (st_rdata),
      .cur   (cur),
      .nxt   (nxt)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_cell) begin
               state_in = ST_FWD;
               phase_in = PH_CELL;
               k_in     = '0;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_FWD: begin
            if (phase_ff == PH_WRITE) begin
               phase_in = PH_CELL;
               if (i_last) begin
                  if (j_last) begin
                     state_in = ST_BWD;
                     k_in     = ADDR_W'(n_cells - N_W'(1));
                     i_in     = w_eff - WV_W'(1);
                     j_in     = h_eff - HV_W'(1);
                  end else begin
                     k_in = k_ff + ADDR_W'(1);
                     i_in = '0;
                     j_in = j_ff + HV_W'(1);
                  end
               end else begin
                  k_in = k_ff + ADDR_W'(1);
                  i_in = i_ff + WV_W'(1);
               end
            end else begin
               phase_in = phase_type'(phase_ff + 3'd1);
            end
         end
         ST_BWD: begin
            if (phase_ff == PH_WRITE) begin
               phase_in = PH_CELL;
               if (i_first) begin
                  if (j_first) begin
                     state_in = ST_FIN;
                  end else begin
                     k_in = k_ff - ADDR_W'(1);
                     i_in = w_eff - WV_W'(1);
                     j_in = j_ff - HV_W'(1);
                  end
               end else begin
                  k_in = k_ff - ADDR_W'(1);
                  i_in = i_ff - WV_W'(1);
               end
            end else begin
               phase_in = phase_type'(phase_ff + 3'd1);
            end
         end
         ST_FIN: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_CELL;
         k_ff        <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         load_pos_ff <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         k_ff        <= k_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         load_pos_ff <= load_pos_in;
      end
   end

   // offsets and squared distance of the cell in the backward pass
   assign dx_now = $signed({1'b0, i_ff}) - $signed({1'b0, ci});
   assign dy_now = $signed({1'b0, j_ff}) - $signed({1'b0, cj});
   assign sq_x   = dx_ff * dx_ff;
   assign sq_y   = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_BWD && phase_ff == PH_CELL) begin
         dx_ff      <= dx_now;
         dy_ff      <= dy_now;
         ctr_hit_ff <= (i_ff == ci) && (j_ff == cj);
      end
      if (state_ff == ST_BWD && phase_ff == PH_NB0) begin
         d2_ff <= D2_W'($unsigned(sq_x)) + D2_W'($unsigned(sq_y));
      end
   end

   // nearest safe cell; backward order, so ties go to the earlier raster cell
   assign take_cell = cell_done_ff && (cur >= cfg.safe_clearance)
                      && (!found_ff || d2_ff <= best_d2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_done_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         cell_done_ff <= (state_ff == ST_BWD) && (phase_ff == PH_WRITE);
         if (state_ff == ST_IDLE) begin
            found_ff <= 1'b0;
         end else if (take_cell) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_cell) begin
         best_d2_ff <= d2_ff;
         best_dx_ff <= dx_ff;
         best_dy_ff <= dy_ff;
      end
      if (cell_done_ff && ctr_hit_ff) begin
         centre_ff <= cur;
      end
   end

   // outcome decision
   always_comb begin
      if (centre_ff >= cfg.safe_clearance) begin
         outcome_now = OUT_SAFE;
      end else if (!found_ff) begin
         outcome_now = OUT_NONE;
      end else if (CMP_W'(best_d2_ff) < CMP_W'(cfg.arrival_sq)) begin
         outcome_now = OUT_ARRIVED;
      end else begin
         outcome_now = OUT_MOVE;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_REPORT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REPORT) begin
         rsp_outcome_ff <= outcome_now;
         rsp_centre_ff  <= centre_ff;
         if (outcome_now == OUT_ARRIVED || outcome_now == OUT_MOVE) begin
            rsp_dx_ff <= OFFSET_W'(best_dx_ff);
            rsp_dy_ff <= OFFSET_W'(best_dy_ff);
         end else begin
            rsp_dx_ff <= '0;
            rsp_dy_ff <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_centre_clearance = rsp_centre_ff;
   assign rsp_target_dx        = rsp_dx_ff;
   assign rsp_target_dy        = rsp_dy_ff;

   // offsets stay zero on a result beat without a target
   assign rsp_offset_ok = !(rsp_valid_ff && (rsp_outcome_ff == OUT_SAFE ||
                                             rsp_outcome_ff == OUT_NONE))
                          || (rsp_dx_ff == '0 && rsp_dy_ff == '0);

   `CHK_ALWAYS(a_single_writer, !(load_we && calc_we), "load and pass write collide")
   `CHK_ALWAYS(a_unused_offset_zero, rsp_offset_ok, "offset set without target")
   `CHK_NEXT(a_report_then_idle, state_ff == ST_REPORT, rsp_valid_ff && state_ff == ST_IDLE, "report not followed by result beat")

endmodule

### src/gctf_store.sv
// distance store: one write port, one registered read port
module gctf_store #(
   parameter int DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [$clog2(DEPTH)-1:0]            waddr,
   input  logic [gctf_pkg::DIST_W-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0]            raddr,
   output logic [gctf_pkg::DIST_W-1:0]         rdata
);
   import gctf_pkg::*;

   logic [DIST_W-1:0] mem_ff [DEPTH];
   logic [DIST_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/gctf_relax.sv
// shared relaxation unit: value load, saturating step add and running minimum
`include "assert_macros.svh"

module gctf_relax #(
   parameter int FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gctf_pkg::relax_ctrl_type      ctrl,
   input  logic [gctf_pkg::DIST_W-1:0]   word,
   output logic [gctf_pkg::DIST_W-1:0]   cur,
   output logic [gctf_pkg::DIST_W-1:0]   nxt
);
   import gctf_pkg::*;

   localparam logic [DIST_W-1:0] STEP_ONE  = DIST_W'(1) << FRAC_BITS;
   localparam logic [DIST_W-1:0] STEP_DIAG = DIST_W'(sqrt2_scaled(FRAC_BITS));

   logic [DIST_W-1:0] cur_ff;
   logic [DIST_W-1:0] cur_in;
   logic [DIST_W-1:0] step;
   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] cand;

   // saturating add of the neighbour word and the step
   always_comb begin
      step = ctrl.diag ? STEP_DIAG : STEP_ONE;
      sum  = {1'b0, word} + {1'b0, step};
      if (word == DIST_INF || sum >= {1'b0, DIST_INF}) begin
         cand = DIST_INF;
      end else begin
         cand = sum[DIST_W-1:0];
      end
   end

   // next running value
   always_comb begin
      unique case (ctrl.op)
         RLX_HOLD:     cur_in = cur_ff;
         RLX_LOAD_MAP: cur_in = (word == '0) ? '0 : DIST_INF;
         RLX_LOAD_RAW: cur_in = word;
         RLX_MIN:      cur_in = (cand < cur_ff) ? cand : cur_ff;
         default:      cur_in = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign cur = cur_ff;
   assign nxt = cur_in;

   `CHK_NEXT(a_min_never_grows, ctrl.op == RLX_MIN, cur_ff <= $past(cur_ff), "relax raised value")
   `CHK_NEXT(a_map_is_binary, ctrl.op == RLX_LOAD_MAP, cur_ff == '0 || cur_ff == DIST_INF, "map not binary")

endmodule

### src/gctf_csr.sv
// configuration registers behind the apb-style port
module gctf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gctf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [gctf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [gctf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output gctf_pkg::cfg_type                  cfg
);
   import gctf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_GRID_WIDTH:  cfg_in.grid_width     = pwdata[GRID_DIM_W-1:0];
            REG_GRID_HEIGHT: cfg_in.grid_height    = pwdata[GRID_DIM_W-1:0];
            REG_SAFE:        cfg_in.safe_clearance = pwdata[SAFE_W-1:0];
            REG_ARRIVAL:     cfg_in.arrival_sq     = pwdata[ARRIVAL_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width     <= GRID_WIDTH_RST;
         cfg_ff.grid_height    <= GRID_HEIGHT_RST;
         cfg_ff.safe_clearance <= SAFE_RST;
         cfg_ff.arrival_sq     <= ARRIVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_GRID_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.grid_height);
         REG_SAFE:        prdata = CSR_DATA_W'(cfg_ff.safe_clearance);
         REG_ARRIVAL:     prdata = CSR_DATA_W'(cfg_ff.arrival_sq);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
